>>> sv/tclw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclw_pkg
// Shared types, codes and helpers for the text cell layout block.
// ----------------------------------------------------------------------------
package tclw_pkg;

  localparam int TAB_STOP    = 8;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // input kinds
  localparam logic [2:0] KIND_FRAME  = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_BODY   = 3'd2;
  localparam logic [2:0] KIND_DOC    = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // result report codes
  localparam logic [1:0] REPORT_CELL   = 2'd0;
  localparam logic [1:0] REPORT_CURSOR = 2'd1;
  localparam logic [1:0] REPORT_STOP   = 2'd2;

  // cell attributes
  localparam logic [1:0] ATTR_PLAIN = 2'd0;
  localparam logic [1:0] ATTR_UNDER = 2'd1;
  localparam logic [1:0] ATTR_BOLD  = 2'd2;

  // configuration register indexes
  localparam logic REG_LINE_WIDTH    = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] LINE_WIDTH_RESET    = 8'd80;
  localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd24;

  // characters
  localparam logic [20:0] CHAR_TAB    = 21'h09;
  localparam logic [20:0] CHAR_NL     = 21'h0A;
  localparam logic [20:0] CHAR_SPACE  = 21'h20;
  localparam logic [20:0] CHAR_LT     = 21'h3C;
  localparam logic [20:0] CHAR_AT     = 21'h40;
  localparam logic [20:0] CHAR_BSLASH = 21'h5C;
  localparam logic [20:0] CHAR_CARET  = 21'h5E;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] code_point;
    logic        mid_line;
    logic        at_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  report;
    logic [20:0] glyph;
    logic [1:0]  attribute;
    logic [7:0]  column;
    logic [7:0]  row;
    logic        cursor_valid;
    logic        last;
  } out_item_t;

  // results of one accepted item, handed to the output buffer
  typedef struct packed {
    logic                          load;
    logic [CNT_W-1:0]              count;
    out_item_t [MAX_RESULTS-1:0]   items;
  } batch_t;

  function automatic out_item_t make_cell(logic [20:0] glyph, logic [1:0] attr,
                                          logic [7:0] col, logic [7:0] row);
    out_item_t c;
    c.report       = REPORT_CELL;
    c.glyph        = glyph;
    c.attribute    = attr;
    c.column       = col;
    c.row          = row;
    c.cursor_valid = 1'b0;
    c.last         = 1'b0;
    return c;
  endfunction

  // column advance, saturating at 255
  function automatic logic [7:0] sat_add(logic [7:0] col, logic [8:0] w);
    logic [8:0] s;
    s = {1'b0, col} + w;
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

>>> sv/tclw_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclw_layout
// Position and cursor state, pane registers, and the per-item layout step
// that produces up to three result beats for the output buffer.
// ----------------------------------------------------------------------------
module tclw_layout (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  tclw_pkg::in_item_t in_data,
  input  logic              accept,
  output tclw_pkg::batch_t  batch
);
  import tclw_pkg::*;

  logic [7:0] line_width;
  logic [7:0] screen_height;
  logic [7:0] cur_column;
  logic [7:0] cur_row;
  logic [7:0] cursor_column;
  logic [7:0] cursor_row;
  logic       cursor_seen;

  logic [7:0] cur_column_next;
  logic [7:0] cur_row_next;
  logic [7:0] cursor_column_next;
  logic [7:0] cursor_row_next;
  logic       cursor_seen_next;

  logic        row_vis;
  logic        is_nl;
  logic        is_tab;
  logic        is_ctrl;
  logic [8:0]  adv;
  logic [8:0]  reach;
  logic        wrap;
  logic [7:0]  wrap_col;
  logic [7:0]  row_after;
  logic [7:0]  col_after;
  logic        after_vis;
  logic [1:0]  glyph_cnt;
  out_item_t   wrap_cell;
  out_item_t   cell_a;
  out_item_t   cell_b;
  out_item_t   cursor_rep;
  out_item_t   stop_rep;
  logic [CNT_W-1:0] count;
  out_item_t [MAX_RESULTS-1:0] items;

  assign row_vis = cur_row < screen_height;
  assign is_nl   = in_data.code_point == CHAR_NL;
  assign is_tab  = in_data.code_point == CHAR_TAB;
  assign is_ctrl = in_data.code_point < CHAR_SPACE;

  // tab runs to the next stop, control codes take two cells
  assign adv = is_tab  ? 9'(TAB_STOP) - 9'(cur_column % TAB_STOP) :
               is_ctrl ? 9'd2 : 9'd1;
  assign reach     = {1'b0, cur_column} + adv;
  assign wrap      = reach >= {1'b0, line_width};
  assign wrap_col  = (line_width != 8'd0) ? line_width - 8'd1 : 8'd0;
  assign row_after = wrap ? cur_row + 8'd1 : cur_row;
  assign col_after = wrap ? 8'd0 : cur_column;
  assign after_vis = row_after < screen_height;

  always_comb begin
    wrap_cell = make_cell(CHAR_BSLASH, ATTR_UNDER, wrap_col, cur_row);
    if (is_ctrl && !is_tab) begin
      cell_a    = make_cell(CHAR_CARET, ATTR_UNDER, col_after, row_after);
      cell_b    = make_cell(in_data.code_point + CHAR_AT, ATTR_UNDER,
                            col_after + 8'd1, row_after);
      glyph_cnt = 2'd2;
    end else begin
      cell_a    = make_cell(in_data.code_point, ATTR_PLAIN, col_after, row_after);
      cell_b    = '0;
      glyph_cnt = is_tab ? 2'd0 : 2'd1;
    end
    if (!after_vis) begin
      glyph_cnt = 2'd0;
    end
  end

  always_comb begin
    cur_column_next    = cur_column;
    cur_row_next       = cur_row;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    cursor_seen_next   = cursor_seen;
    count              = '0;
    items              = '0;
    stop_rep           = '0;
    stop_rep.report    = REPORT_STOP;
    cursor_rep         = '0;

    case (in_data.kind)
      KIND_FRAME: begin
        cur_column_next    = 8'd0;
        cur_row_next       = 8'd0;
        cursor_column_next = 8'd0;
        cursor_row_next    = 8'd0;
        cursor_seen_next   = 1'b0;
      end
      KIND_PREFIX: begin
        if (row_vis) begin
          items[0] = make_cell(in_data.code_point, ATTR_BOLD, cur_column, cur_row);
          count    = CNT_W'(1);
        end
        cur_column_next = sat_add(cur_column, 9'd1);
      end
      KIND_BODY: begin
        if (in_data.mid_line) begin
          if (row_vis) begin
            items[0] = make_cell(CHAR_LT, ATTR_UNDER, cur_column, cur_row);
            count    = CNT_W'(1);
          end
          cur_column_next = sat_add(cur_column, 9'd1);
        end
      end
      KIND_DOC: begin
        if (!row_vis) begin
          items[0] = stop_rep;
          count    = CNT_W'(1);
        end else begin
          if (in_data.at_point) begin
            cursor_column_next = cur_column;
            cursor_row_next    = cur_row;
            cursor_seen_next   = 1'b1;
          end
          if (is_nl) begin
            cur_column_next = 8'd0;
            cur_row_next    = cur_row + 8'd1;
          end else begin
            if (wrap) begin
              items[0] = wrap_cell;
              items[1] = cell_a;
              items[2] = cell_b;
              count    = CNT_W'(glyph_cnt) + CNT_W'(1);
            end else begin
              items[0] = cell_a;
              items[1] = cell_b;
              count    = CNT_W'(glyph_cnt);
            end
            cur_row_next    = row_after;
            cur_column_next = sat_add(col_after, adv);
          end
        end
      end
      KIND_END: begin
        if (in_data.at_point && row_vis) begin
          cursor_column_next = cur_column;
          cursor_row_next    = cur_row;
          cursor_seen_next   = 1'b1;
        end
        cursor_rep.report       = REPORT_CURSOR;
        cursor_rep.column       = cursor_column_next;
        cursor_rep.row          = cursor_row_next;
        cursor_rep.cursor_valid = cursor_seen_next;
        items[0] = cursor_rep;
        count    = CNT_W'(1);
      end
      default: begin
      end
    endcase

    if (count != '0) begin
      items[IDX_W'(count - CNT_W'(1))].last = 1'b1;
    end

    batch.load  = accept;
    batch.count = count;
    batch.items = items;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= LINE_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
      cur_column    <= 8'd0;
      cur_row       <= 8'd0;
      cursor_column <= 8'd0;
      cursor_row    <= 8'd0;
      cursor_seen   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LINE_WIDTH:    line_width    <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        cur_column    <= cur_column_next;
        cur_row       <= cur_row_next;
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
        cursor_seen   <= cursor_seen_next;
      end
    end
  end

endmodule

>>> sv/tclw_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclw_out_buf
// Result register for one item's beats, handed out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tclw_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  tclw_pkg::batch_t   batch,
  output logic               load_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tclw_pkg::out_item_t out_data
);
  import tclw_pkg::*;

  out_item_t        items [MAX_RESULTS];
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic             pop;
  logic             pop_last;

  assign out_valid  = cnt != '0;
  assign out_data   = items[idx];
  assign pop        = out_valid && out_ready;
  assign pop_last   = pop && (CNT_W'(idx) == cnt - CNT_W'(1));
  // next item may load as the final beat of the current one leaves
  assign load_ready = (cnt == '0) || pop_last;

  always_ff @(posedge clk) begin
    if (batch.load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        items[i] <= batch.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (batch.load) begin
      cnt <= batch.count;
      idx <= '0;
    end else if (pop_last) begin
      cnt <= '0;
      idx <= '0;
    end else if (pop) begin
      idx <= idx + IDX_W'(1);
    end
  end

endmodule

>>> sv/text_cell_layout_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_layout_wrap
// Lays a character stream onto a text grid with line wrap and tab expansion.
// ----------------------------------------------------------------------------
// the first result beat of an item, if it has any, is valid in the cycle after accept
// each item yields zero to three result beats, handed out in turn by the
//   single output port; an item with no result beats yields no output
// the next item is accepted in the cycle the previous item's last beat leaves
// reset (synchronous, active high) clears position and cursor record, sets
//   line_width to 80 and screen_height to 24 and empties the output register
module text_cell_layout_wrap (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tclw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tclw_pkg::out_item_t out_data
);
  import tclw_pkg::*;

  batch_t batch;
  logic   accept;

  assign accept = in_valid && in_ready;

  tclw_layout u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .accept    (accept),
    .batch     (batch)
  );

  tclw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_ready_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || (out_ready && out_data.last)))
    else $error("input taken while result beats still pending");

  a_load_shows_beat: assert property (@(posedge clk) disable iff (rst)
    (batch.load && batch.count != '0) |=> out_valid)
    else $error("loaded results not presented");

  a_reports_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.report == REPORT_STOP ||
                   out_data.report == REPORT_CURSOR)) |-> out_data.last)
    else $error("stop or cursor report not the final beat");
`endif

endmodule
